[rtl/co2_pkg.sv]
`timescale 1ns / 1ps

package co2_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV1,
      ST_DIV2,
      ST_EMF,
      ST_PPM1,
      ST_PPM2,
      ST_DIGIT,
      ST_OUT
   } co2_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;       // read transaction accepted, latch temperature, clear sum
      logic store;      // store transaction accepted, write ring
      logic acc_en;     // add one ring entry to the sum
      logic div1;       // sum times reciprocal, reference emf
      logic div2;       // average with correction
      logic emf;        // sensor emf scaling
      logic ppm1;       // compare and piece coefficient product
      logic ppm2;       // ppm from product
      logic digit;      // one decimal digit step
      logic out_load;   // load result register
   } co2_cmd_type;

   typedef struct packed {
      logic acc_last;   // last ring entry being added
   } co2_sts_type;

   localparam int DIGIT_COUNT = 4;

endpackage

[rtl/co2_ctrl.sv]
`timescale 1ns / 1ps

module co2_ctrl
   import co2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_mode,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  co2_sts_type sts,
   output co2_cmd_type cmd
);

   localparam int DIG_W = $clog2(DIGIT_COUNT);

   co2_state_type    state_ff, state_in;
   logic [DIG_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dig_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dig_cnt_ff   <= dig_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      dig_cnt_in = dig_cnt_ff;
      cmd        = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode) begin
                  cmd.load = 1'b1;
                  state_in = ST_ACC;
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (sts.acc_last) begin
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            cmd.div1 = 1'b1;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.div2 = 1'b1;
            state_in = ST_EMF;
         end
         ST_EMF: begin
            cmd.emf  = 1'b1;
            state_in = ST_PPM1;
         end
         ST_PPM1: begin
            cmd.ppm1 = 1'b1;
            state_in = ST_PPM2;
         end
         ST_PPM2: begin
            cmd.ppm2   = 1'b1;
            dig_cnt_in = '0;
            state_in   = ST_DIGIT;
         end
         ST_DIGIT: begin
            cmd.digit  = 1'b1;
            dig_cnt_in = dig_cnt_ff + 1'b1;
            if (dig_cnt_ff == DIG_W'(DIGIT_COUNT - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait until the previous result has been taken
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/co2_dpath.sv]
`timescale 1ns / 1ps

module co2_dpath
   import co2_pkg::*;
#(
   parameter int SAMPLE_COUNT = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  adc_high,
   input  logic [7:0]  adc_low,
   input  logic [9:0]  temperature,
   input  co2_cmd_type cmd,
   output co2_sts_type sts,
   output logic [71:0] rsp_tdata,
   output logic [0:0]  rsp_tuser
);

   localparam int IDX_W = $clog2(SAMPLE_COUNT);
   localparam int SUM_W = 12 + IDX_W;
   localparam logic [SUM_W-1:0] RECIP = SUM_W'((2 ** SUM_W) / SAMPLE_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);
   // floor(x/6) as x*43691 >> 18, floor(x/10) as x*52429 >> 19
   localparam logic [31:0] RECIP6  = 32'd43691;
   localparam logic [16:0] RECIP10 = 17'd52429;

   // reference emf by three linear pieces, floor(x/100) as x*41 >> 12
   function automatic logic [8:0] ref_emf_of(input logic [9:0] t);
      logic [9:0]  x;
      logic [15:0] p;
      logic [8:0]  base;
      logic        hit;
      x    = '0;
      base = '0;
      hit  = 1'b1;
      if (t > 10'd300 && t <= 10'd400) begin
         x    = (t - 10'd300) << 3;
         base = 9'd306;
      end else if (t > 10'd200 && t <= 10'd300) begin
         x    = (t - 10'd200) * 10'd6;
         base = 9'd300;
      end else if (t > 10'd100 && t <= 10'd200) begin
         x    = (t - 10'd100) * 10'd7;
         base = 9'd293;
      end else begin
         hit = 1'b0;
      end
      p = 16'(x) * 16'd41;
      return hit ? (base + 9'(p[15:12])) : 9'd0;
   endfunction

   logic [11:0]          ring_ff [SAMPLE_COUNT];
   logic [IDX_W-1:0]     wr_idx_ff;
   logic [IDX_W-1:0]     acc_cnt_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [9:0]           temp_ff;
   logic [2*SUM_W-1:0]   prod_ff;
   logic [8:0]           ref_ff;
   logic [11:0]          avg_ff;
   logic [9:0]           sens_ff;
   logic                 below_ff;
   logic                 zero_ff;
   logic [15:0]          mul_ff;
   logic [13:0]          base_ff;
   logic [13:0]          ppm_ff;
   logic [13:0]          x_ff;
   logic [3:0]           digit_ff [DIGIT_COUNT];
   logic [71:0]          out_data_ff;
   logic                 out_below_ff;

   logic [11:0]          q0;
   logic [SUM_W-1:0]     rem;
   logic [11:0]          avg_in;
   logic [21:0]          emf_prod;
   logic                 below_in;
   logic [9:0]           diff;
   logic [9:0]           coef;
   logic [13:0]          base_in;
   logic                 zero_in;
   logic [31:0]          p6;
   logic [13:0]          ppm_in;
   logic [30:0]          p10;
   logic [13:0]          q10;
   logic [13:0]          r10;
   logic [7:0]           chr [DIGIT_COUNT];

   assign sts.acc_last = (acc_cnt_ff == LAST_IDX);

   // average correction: reciprocal estimate is exact or one low
   assign q0     = prod_ff[SUM_W+11:SUM_W];
   assign rem    = sum_ff - SUM_W'(q0) * SUM_W'(SAMPLE_COUNT);
   assign avg_in = (rem >= SUM_W'(SAMPLE_COUNT)) ? q0 + 12'd1 : q0;

   assign emf_prod = 22'(avg_ff) * 22'd1000;

   assign below_in = sens_ff > {1'b0, ref_ff};
   assign diff     = {1'b0, ref_ff} - sens_ff;

   // ppm pieces as floor(d*coef/6) + base
   always_comb begin
      coef    = 10'd0;
      base_in = 14'd0;
      zero_in = 1'b0;
      if (below_in || diff == 10'd0 || diff > 10'd75) begin
         zero_in = 1'b1;
      end else if (diff <= 10'd15) begin
         coef    = 10'd100;
         base_in = 14'd350;
      end else if (diff <= 10'd27) begin
         coef    = 10'd200;
         base_in = 14'd600;
      end else begin
         coef    = 10'd625;
         base_in = 14'd1000;
      end
   end

   assign p6     = 32'(mul_ff) * RECIP6;
   assign ppm_in = zero_ff ? 14'd0 : p6[31:18] + base_ff;

   assign p10 = 31'(x_ff) * 31'(RECIP10);
   assign q10 = p10[30:19] < 12'd4095 ? 14'(p10[30:19]) : 14'd0;
   assign r10 = x_ff - q10 * 14'd10;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SAMPLE_COUNT; i++) begin
            ring_ff[i] <= '0;
         end
         wr_idx_ff <= '0;
      end else if (cmd.store) begin
         ring_ff[wr_idx_ff] <= {adc_high, adc_low[7:4]};
         wr_idx_ff <= (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         temp_ff    <= temperature;
         acc_cnt_ff <= '0;
         sum_ff     <= '0;
      end
      if (cmd.acc_en) begin
         sum_ff     <= sum_ff + SUM_W'(ring_ff[acc_cnt_ff]);
         acc_cnt_ff <= acc_cnt_ff + 1'b1;
      end
      if (cmd.div1) begin
         prod_ff <= (2*SUM_W)'(sum_ff) * (2*SUM_W)'(RECIP);
         ref_ff  <= ref_emf_of(temp_ff);
      end
      if (cmd.div2) begin
         avg_ff <= avg_in;
      end
      if (cmd.emf) begin
         sens_ff <= emf_prod[21:12];
      end
      if (cmd.ppm1) begin
         below_ff <= below_in;
         zero_ff  <= zero_in;
         base_ff  <= base_in;
         mul_ff   <= 16'(diff[6:0]) * 16'(coef);
      end
      if (cmd.ppm2) begin
         ppm_ff <= ppm_in;
         x_ff   <= ppm_in;
      end
      // ones digit enters first and ends at the low position
      if (cmd.digit) begin
         x_ff <= q10;
         for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
            digit_ff[i] <= digit_ff[i+1];
         end
         digit_ff[DIGIT_COUNT-1] <= r10[3:0];
      end
      if (cmd.out_load) begin
         out_below_ff <= below_ff;
         out_data_ff  <= {7'd0, chr[0], chr[1], chr[2], chr[3],
                          sens_ff, ref_ff, ppm_ff};
      end
   end

   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         chr[i] = below_ff ? 8'hFF : 8'h30 + 8'(digit_ff[i]);
      end
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_below_ff;

endmodule

[rtl/co2_sensor_ppm_converter_unit.sv]
`timescale 1ns / 1ps

// Gas sensor front end. A store transaction (tuser 0) builds a 12-bit converter
// sample from adc_high and the top nibble of adc_low and writes it into a ring of
// SAMPLE_COUNT entries, cleared at reset; it gives no result. A read transaction
// (tuser 1) sums the ring one entry per cycle, averages it, scales it to the
// sensor emf, compares it with the temperature compensated reference emf and
// returns ppm plus four ASCII digits (0xFF each and ppm 0 when the sensor emf is
// above the reference). After a read is accepted, the ring walk goes through the
// single accumulator, then come two division steps, the emf scaling, two ppm
// steps, four digit steps and the output register load, which waits until the
// previous result has been taken. The input is ready again after that load,
// so a new transaction is not accepted while a read is in progress. Store
// transactions are accepted while a finished result waits on the output.
module co2_sensor_ppm_converter_unit
   import co2_pkg::*;
#(
   parameter int SAMPLE_COUNT = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // adc_high, adc_low, temperature, zero fill
   input  logic [0:0]  req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // gas_ppm, reference_emf, sensor_emf, char_thousands, char_hundreds,
   // char_tens, char_ones, zero fill
   output logic [71:0] rsp_tdata,
   output logic [0:0]  rsp_tuser   // below_reference
);

   co2_cmd_type cmd;
   co2_sts_type sts;

   co2_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   co2_dpath #(
      .SAMPLE_COUNT (SAMPLE_COUNT)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .adc_high    (req_tdata[7:0]),
      .adc_low     (req_tdata[15:8]),
      .temperature (req_tdata[25:16]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
